### rtl/backing_store_map_table_defines.svh
// ----------------------------------------------------------------------------
// Backing-store map table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BACKING_STORE_MAP_TABLE_DEFINES_SVH
`define BACKING_STORE_MAP_TABLE_DEFINES_SVH

// same-cycle implication
`define BSMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsmt: same-cycle check failed");

// next-cycle implication
`define BSMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsmt: next-cycle check failed");

`endif

### rtl/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// bsmt_pkg
// Sizes, action codes and sequencer states of the backing-store map table.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmt_pkg;

  localparam int STORES     = 16;
  localparam int PROCS      = 64;
  localparam int PAGE_BYTES = 4096;

  localparam int STORE_W    = $clog2(STORES);
  localparam int PROC_W     = $clog2(PROCS);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int VPAGE_W    = 20;
  localparam int ENTRY_W    = STORE_W + VPAGE_W;
  localparam int CNT_MAX    = (STORES > PROCS) ? STORES : PROCS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_MAP    = 3'd3,
    ACT_UNMAP  = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC,
    ST_SCAN,
    ST_REL
  } state_t;

endpackage

`default_nettype wire

### rtl/bsmt_ram.sv
// ----------------------------------------------------------------------------
// bsmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/backing_store_map_table.sv
// ----------------------------------------------------------------------------
// Backing-store map table
// Store table and per-process table with allocate, free, lookup, map and
// unmap actions, run one item at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Free, lookup, map and unknown actions end in ST_EXEC; allocate scans stores
// in ST_ALLOC (one store per cycle); unmap of a process holding a store scans
// the process table in ST_SCAN (one process-table RAM read per cycle), then
// releases in ST_REL, else ends in ST_EXEC. busy drops in the cycle out_valid
// rises, so a new item waits for the last. Results cannot be stalled.
// Synchronous reset clears all mapped flags and process valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "backing_store_map_table_defines.svh"

module backing_store_map_table
  import bsmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [5:0]  in_pid,
  input  wire logic [5:0]  in_current_pid,
  input  wire logic [3:0]  in_store_id,
  input  wire logic [31:0] in_vaddr,
  input  wire logic [19:0] in_vpage,
  input  wire logic [7:0]  in_npages,
  output logic             out_valid,
  output logic             out_status,
  output logic [3:0]       out_store_out,
  output logic [19:0]      out_page_index
);

  state_t state_r, state_nxt;

  act_t        act_r;
  logic [5:0]  pid_r;
  logic [5:0]  cur_r;
  logic [3:0]  sid_r;
  logic [31:0] vaddr_r;
  logic [19:0] vpage_r;
  logic [7:0]  np_r;

  logic [STORES-1:0] store_mapped_r;
  logic [5:0]        store_owner_r [STORES];
  logic [7:0]        store_pages_r [STORES];
  logic [19:0]       store_base_r  [STORES];

  logic [PROCS-1:0]  proc_valid_r, proc_valid_nxt;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               chk_r, chk_nxt;
  logic [PROC_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic               shared_r, shared_nxt;
  logic [STORE_W-1:0] bs_r, bs_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_status_r, out_status_nxt;
  logic [3:0]  out_store_r, out_store_nxt;
  logic [19:0] out_pidx_r, out_pidx_nxt;

  logic               st_we;
  logic               st_set;
  logic [STORE_W-1:0] st_idx;

  logic               ram_we;
  logic [PROC_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [PROC_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [STORE_W-1:0] rd_store;
  logic [19:0]        rd_base;

  logic               accept;
  logic               pid_ok;
  logic               cur_ok;
  logic               sid_ok;
  logic               bs_ok;
  logic [PROC_W-1:0]  pid_idx;
  logic [PROC_W-1:0]  cur_idx;
  logic [STORE_W-1:0] sid_idx;
  logic               alloc_end;
  logic               alloc_hit;
  logic               scan_end;
  logic               scan_hit;

  assign accept    = start && (state_r == ST_IDLE);
  assign pid_ok    = 32'(pid_r) < PROCS;
  assign cur_ok    = 32'(cur_r) < PROCS;
  assign sid_ok    = 32'(sid_r) < STORES;
  assign bs_ok     = 32'(bs_r) < STORES;
  assign pid_idx   = PROC_W'(pid_r);
  assign cur_idx   = PROC_W'(cur_r);
  assign sid_idx   = STORE_W'(sid_r);
  assign rd_store  = ram_rdata[ENTRY_W-1 -: STORE_W];
  assign rd_base   = ram_rdata[VPAGE_W-1:0];
  assign alloc_end = 32'(cnt_r) >= STORES;
  assign alloc_hit = !alloc_end && !store_mapped_r[cnt_r[STORE_W-1:0]];
  assign scan_end  = 32'(cnt_r) >= PROCS;
  assign scan_hit  = chk_r && (chk_idx_r != pid_idx) && proc_valid_r[chk_idx_r]
                     && (rd_store == bs_r);

  assign ram_raddr = (state_r == ST_SCAN) ? cnt_r[PROC_W-1:0] : PROC_W'(in_pid);

  bsmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PROCS)
  ) u_proc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (act_r == ACT_ALLOC) begin
          state_nxt = ST_ALLOC;
        end else if (act_r == ACT_UNMAP && pid_ok && proc_valid_r[pid_idx]) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_ALLOC: begin
        if (alloc_end || alloc_hit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    proc_valid_nxt = proc_valid_r;
    cnt_nxt        = cnt_r;
    chk_nxt        = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    shared_nxt     = shared_r;
    bs_nxt         = bs_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_store_nxt  = out_store_r;
    out_pidx_nxt   = out_pidx_r;
    st_we          = 1'b0;
    st_set         = 1'b0;
    st_idx         = sid_idx;
    ram_we         = 1'b0;
    ram_waddr      = pid_idx;
    ram_wdata      = {sid_idx, vpage_r};
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        out_status_nxt = 1'b1;
        out_store_nxt  = '0;
        out_pidx_nxt   = '0;
        cnt_nxt        = '0;
        unique case (act_r)
          ACT_ALLOC: begin
          end
          ACT_FREE: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            st_we          = sid_ok;
            if (cur_ok) begin
              proc_valid_nxt[cur_idx] = 1'b0;
            end
          end
          ACT_LOOKUP: begin
            out_valid_nxt = 1'b1;
            if (pid_ok && proc_valid_r[pid_idx]) begin
              out_status_nxt = 1'b0;
              out_store_nxt  = 4'(rd_store);
              out_pidx_nxt   = 20'(vaddr_r >> PAGE_SHIFT) - rd_base;
            end
          end
          ACT_MAP: begin
            out_valid_nxt = 1'b1;
            if (pid_r == cur_r && pid_ok && sid_ok) begin
              out_status_nxt          = 1'b0;
              st_we                   = 1'b1;
              st_set                  = 1'b1;
              ram_we                  = 1'b1;
              proc_valid_nxt[pid_idx] = 1'b1;
            end
          end
          ACT_UNMAP: begin
            out_status_nxt = 1'b0;
            if (pid_ok && proc_valid_r[pid_idx]) begin
              bs_nxt     = rd_store;
              cnt_nxt    = CNT_W'(1);
              shared_nxt = 1'b0;
            end else begin
              out_valid_nxt = 1'b1;
              if (pid_ok) begin
                proc_valid_nxt[pid_idx] = 1'b0;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      ST_ALLOC: begin
        if (alloc_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_store_nxt  = 4'(cnt_r);
        end else if (alloc_end) begin
          out_valid_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        shared_nxt = shared_r | scan_hit;
        if (!scan_end) begin
          chk_nxt     = 1'b1;
          chk_idx_nxt = cnt_r[PROC_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
      end
      ST_REL: begin
        out_valid_nxt = 1'b1;
        if (!shared_r) begin
          st_we  = bs_ok;
          st_idx = bs_r;
          if (cur_ok) begin
            proc_valid_nxt[cur_idx] = 1'b0;
          end
        end
        proc_valid_nxt[pid_idx] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      store_mapped_r <= '0;
      proc_valid_r   <= '0;
      out_valid_r    <= 1'b0;
      chk_r          <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_r        <= chk_nxt;
      if (st_we) begin
        store_mapped_r[st_idx] <= st_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= act_t'(in_action);
      pid_r   <= in_pid;
      cur_r   <= in_current_pid;
      sid_r   <= in_store_id;
      vaddr_r <= in_vaddr;
      vpage_r <= in_vpage;
      np_r    <= in_npages;
    end
    if (st_we) begin
      store_owner_r[st_idx] <= st_set ? pid_r : '0;
      store_pages_r[st_idx] <= st_set ? np_r : '0;
      store_base_r[st_idx]  <= st_set ? vpage_r : '0;
    end
    cnt_r        <= cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    shared_r     <= shared_nxt;
    bs_r         <= bs_nxt;
    out_status_r <= out_status_nxt;
    out_store_r  <= out_store_nxt;
    out_pidx_r   <= out_pidx_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_store_out  = out_store_r;
  assign out_page_index = out_pidx_r;

  `BSMT_ASSERT_IMP(a_out_when_idle, out_valid_r, state_r == ST_IDLE)
  `BSMT_ASSERT_NXT(a_accept_to_exec, start && !busy, state_r == ST_EXEC)
  `BSMT_ASSERT_IMP(a_scan_cnt_range, state_r == ST_SCAN,
                   cnt_r != '0 && 32'(cnt_r) <= PROCS)
  `BSMT_ASSERT_IMP(a_alloc_free_store,
                   out_valid_r && act_r == ACT_ALLOC && !out_status_r,
                   !store_mapped_r[STORE_W'(out_store_r)])

endmodule

`default_nettype wire

### bench/bsmt_result_monitor.sv
// ----------------------------------------------------------------------------
// Backing-store map table result monitor
// Watches the command and result channels. Keeps its own copy of the store
// and process tables, predicts the result of every accepted item and
// compares it with the next result strobed out.
// ----------------------------------------------------------------------------
module bsmt_result_monitor
  import bsmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_action,
  input  logic [5:0]  in_pid,
  input  logic [5:0]  in_current_pid,
  input  logic [3:0]  in_store_id,
  input  logic [31:0] in_vaddr,
  input  logic [19:0] in_vpage,
  input  logic [7:0]  in_npages,
  input  logic        out_valid,
  input  logic        out_status,
  input  logic [3:0]  out_store_out,
  input  logic [19:0] out_page_index,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic               status;
    logic [STORE_W-1:0] store;
    logic [VPAGE_W-1:0] page_index;
  } map_result_t;

  logic               store_in_use  [STORES];
  logic               proc_mapped   [PROCS];
  logic [STORE_W-1:0] proc_store_id [PROCS];
  logic [VPAGE_W-1:0] proc_vbase    [PROCS];

  map_result_t pending_results[$];
  map_result_t oldest;
  map_result_t observed;

  function automatic void clear_process(logic [PROC_W-1:0] p);
    proc_mapped[p]   = 1'b0;
    proc_store_id[p] = '0;
    proc_vbase[p]    = '0;
  endfunction

  function automatic void free_store(logic [STORE_W-1:0] s, logic [PROC_W-1:0] cur);
    store_in_use[s] = 1'b0;
    clear_process(cur);
  endfunction

  function automatic map_result_t apply_action(
    logic [2:0]         act,
    logic [PROC_W-1:0]  pid,
    logic [PROC_W-1:0]  cur,
    logic [STORE_W-1:0] sid,
    logic [31:0]        vaddr,
    logic [VPAGE_W-1:0] vpage
  );
    map_result_t        r;
    logic [STORE_W-1:0] held;
    bit                 shared;
    r = '{status: 1'b1, store: '0, page_index: '0};
    case (act)
      ACT_ALLOC: begin
        for (int i = 0; i < STORES; i++) begin
          if (!store_in_use[i]) begin
            r.status = 1'b0;
            r.store  = STORE_W'(i);
            break;
          end
        end
      end
      ACT_FREE: begin
        free_store(sid, cur);
        r.status = 1'b0;
      end
      ACT_LOOKUP: begin
        if (proc_mapped[pid]) begin
          r.status     = 1'b0;
          r.store      = proc_store_id[pid];
          r.page_index = VPAGE_W'((vaddr >> PAGE_SHIFT) - proc_vbase[pid]);
        end
      end
      ACT_MAP: begin
        if (pid == cur) begin
          store_in_use[sid]  = 1'b1;
          proc_mapped[pid]   = 1'b1;
          proc_store_id[pid] = sid;
          proc_vbase[pid]    = vpage;
          r.status           = 1'b0;
        end
      end
      ACT_UNMAP: begin
        r.status = 1'b0;
        if (proc_mapped[pid]) begin
          held   = proc_store_id[pid];
          shared = 1'b0;
          for (int i = 1; i < PROCS; i++) begin
            if (i != pid && proc_mapped[i] && proc_store_id[i] == held)
              shared = 1'b1;
          end
          if (!shared)
            free_store(held, cur);
        end
        clear_process(pid);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORES; i++)
        store_in_use[i] = 1'b0;
      for (int i = 0; i < PROCS; i++)
        clear_process(PROC_W'(i));
      pending_results.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        observed = '{status: out_status, store: out_store_out, page_index: out_page_index};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: status %0d store %0d page_index %h",
                     $realtime, observed.status, observed.store, observed.page_index);
        end else begin
          oldest = pending_results.pop_front();
          if (oldest != observed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp/act: status %0d/%0d store %0d/%0d page_index %h/%h",
                       $realtime, oldest.status, observed.status, oldest.store,
                       observed.store, oldest.page_index, observed.page_index);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_action(in_action, in_pid, in_current_pid,
                                               in_store_id, in_vaddr, in_vpage));
      outstanding <= pending_results.size();
    end
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Backing-store map table testbench
// Drives directed and random allocate, free, lookup, map, unmap and unknown
// action commands, the random ones in bursts with random gaps; the result
// monitor predicts and checks every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bsmt_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_ITEMS = 500;
  localparam logic [2:0] ACT_RESERVED = 3'd5;
  localparam logic [2:0] ACT_TOP_CODE = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [5:0]  in_pid;
  logic [5:0]  in_current_pid;
  logic [3:0]  in_store_id;
  logic [31:0] in_vaddr;
  logic [19:0] in_vpage;
  logic [7:0]  in_npages;
  logic        out_valid;
  logic        out_status;
  logic [3:0]  out_store_out;
  logic [19:0] out_page_index;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;

  backing_store_map_table dut (.*);
  bsmt_result_monitor u_monitor (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** backing_store_map_table: FAILED **");
      $finish;
    end
  end

  task automatic issue(input logic [2:0] act, input logic [5:0] pid, input logic [5:0] cur,
                       input logic [3:0] sid, input logic [31:0] va, input logic [19:0] vp,
                       input logic [7:0] np);
    in_action      <= act;
    in_pid         <= pid;
    in_current_pid <= cur;
    in_store_id    <= sid;
    in_vaddr       <= va;
    in_vpage       <= vp;
    in_npages      <= np;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int         roll;
    logic [2:0] act;
    logic [5:0] pid;
    logic [5:0] cur;
    roll = $urandom_range(99);
    if (roll < 8)       act = ACT_ALLOC;
    else if (roll < 20) act = ACT_FREE;
    else if (roll < 45) act = ACT_LOOKUP;
    else if (roll < 75) act = ACT_MAP;
    else if (roll < 93) act = ACT_UNMAP;
    else                act = 3'($urandom_range(ACT_TOP_CODE, ACT_RESERVED));
    pid = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(11));
    if (act == ACT_MAP && $urandom_range(9) != 0)
      cur = pid;
    else if ($urandom_range(3) == 0)
      cur = 6'($urandom);
    else
      cur = 6'($urandom_range(11));
    issue(act, pid, cur, 4'($urandom), $urandom, 20'($urandom), 8'($urandom));
  endtask

  initial begin
    int burst_left;
    int gap;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = '0;
    in_pid         = '0;
    in_current_pid = '0;
    in_store_id    = '0;
    in_vaddr       = '0;
    in_vpage       = '0;
    in_npages      = '0;
    burst_left     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(ACT_LOOKUP, 6'd5, 6'd5, 4'd0, 32'h0000_5000, 20'h0, 8'h0);
    issue(ACT_TOP_CODE, 6'd5, 6'd5, 4'd1, 32'h0, 20'h0, 8'h0);
    issue(ACT_MAP, 6'd3, 6'd4, 4'd0, 32'h0, 20'h0_0010, 8'h10);
    issue(ACT_MAP, 6'd3, 6'd3, 4'd0, 32'h0, 20'hFFFFF, 8'hFF);
    issue(ACT_LOOKUP, 6'd3, 6'd3, 4'd0, 32'h0, 20'h0, 8'h0);
    issue(ACT_MAP, 6'd7, 6'd7, 4'd0, 32'h0, 20'h0, 8'h0);
    issue(ACT_UNMAP, 6'd3, 6'd7, 4'd0, 32'h0, 20'h0, 8'h0);
    issue(ACT_MAP, 6'd0, 6'd0, 4'd2, 32'h0, 20'h12345, 8'h20);
    issue(ACT_MAP, 6'd1, 6'd1, 4'd2, 32'h0, 20'h54321, 8'h40);
    issue(ACT_UNMAP, 6'd1, 6'd7, 4'd0, 32'h0, 20'h0, 8'h0);
    issue(ACT_LOOKUP, 6'd7, 6'd7, 4'd0, 32'hFFFF_FFFF, 20'h0, 8'h0);
    issue(ACT_FREE, 6'd0, 6'd0, 4'd0, 32'h0, 20'h0, 8'h0);
    for (int s = 0; s < STORES; s++)
      issue(ACT_MAP, 6'(63 - s), 6'(63 - s), 4'(s), $urandom,
            s[0] ? 20'hFFFFF : 20'h0, s[0] ? 8'hFF : 8'h00);
    issue(ACT_ALLOC, 6'd0, 6'd0, 4'd0, 32'h0, 20'h0, 8'h0);
    issue(ACT_LOOKUP, 6'd63, 6'd63, 4'hF, 32'hFFFF_FFFF, 20'h0, 8'h0);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 1);
        gap = ($urandom_range(3) == 0) ? $urandom_range(80, 5) : $urandom_range(4, 0);
        if (gap != 0)
          idle(gap);
      end
      if (n == RANDOM_ITEMS / 2)
        drain();
      random_item();
      burst_left--;
    end

    drain();
    repeat (PROCS + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("** backing_store_map_table: PASSED **");
    else
      $display("** backing_store_map_table: FAILED **");
    $finish;
  end

endmodule
